[rtl/core/pmu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_pkg
// Types, constants and helpers shared by the particle midpoint update block.
// ----------------------------------------------------------------------------
package pmu_pkg;

   localparam int FIX_W      = 32;          // signed Q16.16 word
   localparam int UFIX_W     = 31;          // unsigned Q15.16 word
   localparam int PROD_W     = 64;          // Q32.32 product
   localparam int DIV_STEPS  = 31;          // quotient bits below saturation
   localparam int ACC_LAT    = 3 + DIV_STEPS + 1;
   localparam int PIPE_DEPTH = 2 * ACC_LAT + 5;
   localparam int CSR_IDX_W  = 2;
   localparam int HALF_SHIFT = 17;
   localparam int FULL_SHIFT = 16;

   typedef logic signed [FIX_W-1:0] fix_type;
   typedef logic [UFIX_W-1:0]       ufix_type;

   localparam fix_type  FIX_MAX  = 32'sh7FFF_FFFF;
   localparam fix_type  FIX_MIN  = 32'sh8000_0000;
   localparam ufix_type DT_RESET = 31'd655;
   localparam logic [FIX_W-1:0] AGE_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAVITY   = 2'd0,
      CSR_DRAG      = 2'd1,
      CSR_TIME_STEP = 2'd2
   } csr_index_type;

   typedef struct packed {
      fix_type          pos_x;
      fix_type          pos_y;
      fix_type          pos_z;
      fix_type          vel_x;
      fix_type          vel_y;
      fix_type          vel_z;
      ufix_type         particle_mass;
      logic             is_fixed;
      logic [FIX_W-1:0] age_in;
   } req_type;

   typedef struct packed {
      fix_type          new_pos_x;
      fix_type          new_pos_y;
      fix_type          new_pos_z;
      fix_type          new_vel_x;
      fix_type          new_vel_y;
      fix_type          new_vel_z;
      logic [FIX_W-1:0] age_out;
   } rsp_type;

   // Particle as it travels down the pipeline; mid holds the midpoint velocity.
   typedef struct packed {
      logic [2:0][FIX_W-1:0] pos;
      logic [2:0][FIX_W-1:0] vel;
      logic [2:0][FIX_W-1:0] mid;
      ufix_type              mass;
      logic                  fixed;
      logic [FIX_W-1:0]      age;
   } item_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic fix_type sat32(input logic signed [PROD_W-1:0] x);
      fix_type r;
      if ((x[PROD_W-1:FIX_W-1] == '0) || (x[PROD_W-1:FIX_W-1] == '1)) begin
         r = x[FIX_W-1:0];
      end else if (x[PROD_W-1]) begin
         r = FIX_MIN;
      end else begin
         r = FIX_MAX;
      end
      return r;
   endfunction

endpackage

[rtl/core/pmu_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface pmu_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/pmu_accel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_accel
// Pipelined acceleration a = sat32(F / m), F = -drag * v - g * m (vertical); zero if fixed or massless.
// ----------------------------------------------------------------------------
module pmu_accel (
   input  logic              clock,
   input  logic              en,
   input  pmu_pkg::fix_type  vel,
   input  pmu_pkg::ufix_type mass,
   input  logic              is_fixed,
   input  logic              vertical,
   input  pmu_pkg::ufix_type gravity,
   input  pmu_pkg::ufix_type drag,
   output pmu_pkg::fix_type  accel
);
   import pmu_pkg::*;

   typedef struct packed {
      logic ovf;
      logic neg;
      logic zero;
   } div_flag_type;

   // stage 1: products
   logic signed [PROD_W-1:0] drag_prod_ff;
   logic [2*UFIX_W-1:0]      grav_prod_ff;
   ufix_type                 m1_ff;
   logic                     zero1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         drag_prod_ff <= $signed({1'b0, drag}) * vel;
         grav_prod_ff <= vertical ? gravity * mass : '0;
         m1_ff        <= mass;
         zero1_ff     <= is_fixed || (mass == '0);
      end
   end

   // stage 2: force and its magnitude
   logic signed [PROD_W-1:0] force_val;
   logic [PROD_W-1:0]        mag_in;
   logic [PROD_W-1:0]        mag2_ff;
   logic                     neg2_ff;
   ufix_type                 m2_ff;
   logic                     zero2_ff;

   always_comb begin
      force_val = -drag_prod_ff - $signed({2'b00, grav_prod_ff});
      mag_in    = force_val[PROD_W-1] ? PROD_W'(-force_val) : force_val;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag2_ff  <= mag_in;
         neg2_ff  <= force_val[PROD_W-1];
         m2_ff    <= m1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   // stage 3: overflow check, then one quotient bit per stage
   ufix_type     rem_ff [DIV_STEPS];
   ufix_type     quo_ff [DIV_STEPS+1];
   ufix_type     m_ff   [DIV_STEPS];
   div_flag_type flg_ff [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]      <= mag2_ff[2*UFIX_W-1:UFIX_W];
         quo_ff[0]      <= mag2_ff[UFIX_W-1:0];
         m_ff[0]        <= m2_ff;
         flg_ff[0].ovf  <= mag2_ff[PROD_W-1:UFIX_W] >= {2'b00, m2_ff};
         flg_ff[0].neg  <= neg2_ff;
         flg_ff[0].zero <= zero2_ff;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [UFIX_W:0] trial;
      logic            ge;

      assign trial = {rem_ff[k], quo_ff[k][UFIX_W-1]};
      assign ge    = trial >= {1'b0, m_ff[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[k+1] <= {quo_ff[k][UFIX_W-2:0], ge};
            flg_ff[k+1] <= flg_ff[k];
         end
      end

      if (k < DIV_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= ge ? UFIX_W'(trial - {1'b0, m_ff[k]}) : trial[UFIX_W-1:0];
               m_ff[k+1]   <= m_ff[k];
            end
         end
      end
   end

   // final stage: sign and saturation
   fix_type accel_ff;
   fix_type quo_pos;

   assign quo_pos = {1'b0, quo_ff[DIV_STEPS]};

   always_ff @(posedge clock) begin
      if (en) begin
         if (flg_ff[DIV_STEPS].zero) begin
            accel_ff <= '0;
         end else if (flg_ff[DIV_STEPS].ovf) begin
            accel_ff <= flg_ff[DIV_STEPS].neg ? FIX_MIN : FIX_MAX;
         end else begin
            accel_ff <= flg_ff[DIV_STEPS].neg ? -quo_pos : quo_pos;
         end
      end
   end

   assign accel = accel_ff;

endmodule

[rtl/core/particle_midpoint_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_midpoint_update
// Advances one particle by a midpoint step under gravity and viscous drag.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req_if   in   valid/ready        position, velocity, mass, fixed, age
//  rsp_if   out  valid/ready        new position, new velocity, age
//  csr_*    in   csr_we only        gravity, drag, time step (index 0..2)
//
//  One transaction enters per cycle unless rsp_if stalls; the depth comes from
//  two 35-stage acceleration pipelines in series (one bit of quotient per divider stage).
//  Reset clears the valid bits and loads the registers; no clearing pass.
//  A result waiting at rsp_if freezes the whole pipeline; nothing is lost
//  or repeated, and intake resumes the cycle the result is taken.
// ----------------------------------------------------------------------------
module particle_midpoint_update (
   input  logic                           clock,
   input  logic                           reset,
   pmu_stream_if.sink                     req_if,
   pmu_stream_if.source                   rsp_if,
   input  logic                           csr_we,
   input  logic [pmu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  pmu_pkg::ufix_type              csr_wdata
);
   import pmu_pkg::*;

   // ---------------------------------------------------------------- config
   ufix_type gravity_ff;
   ufix_type drag_ff;
   ufix_type dt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= '0;
         drag_ff    <= '0;
         dt_ff      <= DT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRAVITY:   gravity_ff <= csr_wdata;
            CSR_DRAG:      drag_ff    <= csr_wdata;
            CSR_TIME_STEP: dt_ff      <= csr_wdata;
            default:       ;  // drop writes to unmapped indexes
         endcase
      end
   end

   // -------------------------------------------------------------- control
   // Advance everything together; hold while a result waits downstream.
   logic                  adv;
   logic [PIPE_DEPTH-1:0] vld_ff;

   assign adv          = !(rsp_if.valid && !rsp_if.ready);
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_if.valid};
      end
   end

   // --------------------------------------------------------- intake item
   item_type item_in;

   always_comb begin
      item_in        = '0;
      item_in.pos[0] = req_if.payload.pos_x;
      item_in.pos[1] = req_if.payload.pos_y;
      item_in.pos[2] = req_if.payload.pos_z;
      item_in.vel[0] = req_if.payload.vel_x;
      item_in.vel[1] = req_if.payload.vel_y;
      item_in.vel[2] = req_if.payload.vel_z;
      item_in.mass   = req_if.payload.particle_mass;
      item_in.fixed  = req_if.payload.is_fixed;
      item_in.age    = req_if.payload.age_in;
   end

   // Carry the particle alongside the first acceleration pipeline.
   item_type dly0_ff [ACC_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         dly0_ff[0] <= item_in;
         for (int j = 1; j < ACC_LAT; j++) begin
            dly0_ff[j] <= dly0_ff[j-1];
         end
      end
   end

   // -------------------------------------------------- half step per axis
   fix_type                  acc0    [3];
   fix_type                  acc1    [3];
   logic signed [PROD_W-1:0] hp_ff   [3];
   item_type                 h1_item_ff;
   item_type                 h2_item_in;
   item_type                 h2_item_ff;

   for (genvar i = 0; i < 3; i++) begin : g_half
      pmu_accel u_acc0 (
         .clock    (clock),
         .en       (adv),
         .vel      ($signed(item_in.vel[i])),
         .mass     (item_in.mass),
         .is_fixed (item_in.fixed),
         .vertical (i == 1),
         .gravity  (gravity_ff),
         .drag     (drag_ff),
         .accel    (acc0[i])
      );

      always_ff @(posedge clock) begin
         if (adv) begin
            hp_ff[i] <= acc0[i] * $signed({1'b0, dt_ff});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h1_item_ff <= dly0_ff[ACC_LAT-1];
      end
   end

   // Midpoint velocity: v + a0 * dt / 2, floor shift then saturate.
   always_comb begin
      h2_item_in = h1_item_ff;
      for (int j = 0; j < 3; j++) begin
         h2_item_in.mid[j] = sat32(PROD_W'($signed(h1_item_ff.vel[j]))
                                   + (hp_ff[j] >>> HALF_SHIFT));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h2_item_ff <= h2_item_in;
      end
   end

   // -------------------------------------------------- full step per axis
   item_type dly1_ff [ACC_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         dly1_ff[0] <= h2_item_ff;
         for (int j = 1; j < ACC_LAT; j++) begin
            dly1_ff[j] <= dly1_ff[j-1];
         end
      end
   end

   logic signed [PROD_W-1:0] vp_ff  [3];
   logic signed [PROD_W-1:0] pp_ff  [3];
   fix_type                  npos_ff [3];
   fix_type                  nvel_ff [3];
   item_type                 f1_item_ff;
   logic [FIX_W-1:0]         f2_age_ff;

   for (genvar i = 0; i < 3; i++) begin : g_full
      pmu_accel u_acc1 (
         .clock    (clock),
         .en       (adv),
         .vel      ($signed(h2_item_ff.mid[i])),
         .mass     (h2_item_ff.mass),
         .is_fixed (h2_item_ff.fixed),
         .vertical (i == 1),
         .gravity  (gravity_ff),
         .drag     (drag_ff),
         .accel    (acc1[i])
      );

      always_ff @(posedge clock) begin
         if (adv) begin
            vp_ff[i]   <= acc1[i] * $signed({1'b0, dt_ff});
            pp_ff[i]   <= $signed(dly1_ff[ACC_LAT-1].mid[i]) * $signed({1'b0, dt_ff});
            npos_ff[i] <= sat32(PROD_W'($signed(f1_item_ff.pos[i]))
                                + (pp_ff[i] >>> FULL_SHIFT));
            nvel_ff[i] <= sat32(PROD_W'($signed(f1_item_ff.vel[i]))
                                + (vp_ff[i] >>> FULL_SHIFT));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_item_ff <= dly1_ff[ACC_LAT-1];
         f2_age_ff  <= f1_item_ff.age;
      end
   end

   // ------------------------------------------------ bounce, age, output
   rsp_type rsp_in;
   rsp_type rsp_ff;

   always_comb begin
      rsp_in.new_pos_x = npos_ff[0];
      rsp_in.new_pos_y = npos_ff[1];
      rsp_in.new_pos_z = npos_ff[2];
      rsp_in.new_vel_x = nvel_ff[0];
      rsp_in.new_vel_z = nvel_ff[2];
      // below ground: reflect the vertical velocity
      if (npos_ff[1][FIX_W-1]) begin
         rsp_in.new_vel_y = (nvel_ff[1] == FIX_MIN) ? FIX_MAX : -nvel_ff[1];
      end else begin
         rsp_in.new_vel_y = nvel_ff[1];
      end
      rsp_in.age_out = (f2_age_ff == AGE_MAX) ? AGE_MAX : f2_age_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid   = vld_ff[PIPE_DEPTH-1];
   assign rsp_if.payload = rsp_ff;

   // ------------------------------------------------------------ checks
   a_stall_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !req_if.ready)
      else $error("intake open while output stalled");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> vld_ff[0])
      else $error("accepted transaction missing from pipeline");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result valid right after reset");

endmodule
